@@ design/cfbc_pkg.sv @@
// Shared types and constants for the command frame builder with checksum.
package cfbc_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned HEAD_COUNT  = 6;
   localparam int unsigned STEP_W      = 3;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   localparam logic [BYTE_W-1:0] PREAMBLE_RESET = 8'h02;

   localparam logic ACTION_HEADER  = 1'b0;
   localparam logic ACTION_PAYLOAD = 1'b1;

   localparam logic [STEP_W-1:0] HEAD_BYTES    = 3'd6;
   localparam logic [STEP_W-1:0] PAYLOAD_BYTES = 3'd1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [HEAD_COUNT-1:0][BYTE_W-1:0] data;
      logic [STEP_W-1:0]                 data_count;
      logic                              has_checksum;
      byte_type                          checksum;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ design/cfbc_front.sv @@
// Front end: accepts items, tracks the open frame and the running sum, and queues work.
module cfbc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [15:0]           req_address,
   input  logic [7:0]            req_command_code,
   input  logic [7:0]            req_command_type,
   input  logic [7:0]            req_payload_length,
   input  logic [7:0]            req_payload_byte,
   input  cfbc_pkg::byte_type    preamble,
   input  cfbc_pkg::qstat_type   qstat,
   output cfbc_pkg::push_type    push_out
);

   logic                 open_ff, open_in;
   cfbc_pkg::byte_type   remaining_ff, remaining_in;
   cfbc_pkg::byte_type   sum_ff, sum_in;
   logic                 accept;
   cfbc_pkg::byte_type   head_sum;
   cfbc_pkg::byte_type   pay_sum;
   cfbc_pkg::entry_type  entry;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   assign head_sum = 8'(preamble + req_address[7:0] + req_address[15:8]
                        + req_command_code + req_command_type + req_payload_length);
   assign pay_sum  = 8'(sum_ff + req_payload_byte);

   always_comb begin
      open_in      = open_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      entry        = '0;
      push_out     = '0;
      if (accept) begin
         if (req_action == cfbc_pkg::ACTION_HEADER) begin
            entry.data[0]    = preamble;
            entry.data[1]    = req_address[7:0];
            entry.data[2]    = req_address[15:8];
            entry.data[3]    = req_command_code;
            entry.data[4]    = req_command_type;
            entry.data[5]    = req_payload_length;
            entry.data_count = cfbc_pkg::HEAD_BYTES;
            entry.checksum   = 8'(8'd0 - head_sum);
            sum_in           = head_sum;
            if (req_payload_length == 8'd0) begin
               entry.has_checksum = 1'b1;
               open_in            = 1'b0;
               remaining_in       = 8'd0;
            end else begin
               open_in      = 1'b1;
               remaining_in = req_payload_length;
            end
            push_out.push = 1'b1;
         end else if (open_ff) begin
            entry.data[0]    = req_payload_byte;
            entry.data_count = cfbc_pkg::PAYLOAD_BYTES;
            entry.checksum   = 8'(8'd0 - pay_sum);
            sum_in           = pay_sum;
            if (remaining_ff == 8'd1) begin
               entry.has_checksum = 1'b1;
               open_in            = 1'b0;
               remaining_in       = 8'd0;
            end else begin
               remaining_in = 8'(remaining_ff - 8'd1);
            end
            push_out.push = 1'b1;
         end
      end
      push_out.entry = entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         remaining_ff <= '0;
         sum_ff       <= '0;
      end else begin
         open_ff      <= open_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

@@ design/cfbc_queue.sv @@
// Short queue of work entries between the front end and the back end.
module cfbc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  cfbc_pkg::push_type   push_in,
   input  logic                 pop,
   output cfbc_pkg::entry_type  head,
   output cfbc_pkg::qstat_type  qstat
);

   cfbc_pkg::entry_type                 slot_ff [cfbc_pkg::QUEUE_DEPTH];
   logic [cfbc_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [cfbc_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [cfbc_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == cfbc_pkg::QCNT_W'(cfbc_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push_in.push ? cfbc_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? cfbc_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push && !pop) begin
         count_in = cfbc_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push_in.push) begin
         count_in = cfbc_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/cfbc_back.sv @@
// Back end: serialises queued entries into frame bytes through an output register.
module cfbc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cfbc_pkg::entry_type  head,
   input  cfbc_pkg::qstat_type  qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_frame_end
);

   logic [cfbc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        valid_ff, valid_in;
   cfbc_pkg::byte_type          byte_ff, byte_in;
   logic                        end_ff, end_in;
   logic                        load;
   logic                        at_checksum;
   logic [cfbc_pkg::STEP_W-1:0] last_step;

   assign load        = !qstat.empty && (!valid_ff || !rsp_stall);
   assign at_checksum = (step_ff == head.data_count);
   assign last_step   = head.has_checksum ? head.data_count
                                          : cfbc_pkg::STEP_W'(head.data_count - 1'b1);

   always_comb begin
      step_in  = step_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      valid_in = valid_ff && rsp_stall;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = at_checksum ? head.checksum : head.data[step_ff];
         end_in   = at_checksum;
         if (step_ff == last_step) begin
            pop     = 1'b1;
            step_in = '0;
         end else begin
            step_in = cfbc_pkg::STEP_W'(step_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_end  = end_ff;

endmodule

@@ design/command_frame_builder_checksum.sv @@
// Top level of the command frame builder with two's complement byte-sum checksum.
// The req channel takes header items (action 0) and payload items (action 1) under
// valid and stall; an item transfers at a clock edge with req_valid high and req_stall low.
// A header yields the preamble, address low and high bytes, code, type and length on the
// rsp channel, followed by the checksum marked with rsp_frame_end when the length is zero.
// Each payload byte of an open frame passes through, and the last one is followed by the
// checksum. Payload bytes with no open frame are dropped without output.
// The csr port writes the preamble byte; write it only while the block is idle.
// The first byte of an item is written into the queue at its transfer, then loaded into
// the output register, where it can itself transfer. The serialiser emits one byte per
// cycle while the queue holds an entry and rsp_stall is low, so payload items stream at
// one per cycle (the last of a frame is followed by its checksum) while headers occupy it
// for six or seven bytes; a two-entry queue lets the front end take items in the meantime.
// When the receiver asserts rsp_stall the output byte holds, the queue fills and req_stall
// rises once both queue entries are taken.
// Synchronous reset empties the queue and output register, closes any open frame, clears
// the running sum and sets the preamble to 2.
module command_frame_builder_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_command_code,
   input  logic [7:0]  req_command_type,
   input  logic [7:0]  req_payload_length,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_end,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   cfbc_pkg::byte_type   preamble_ff, preamble_in;
   cfbc_pkg::push_type   push;
   cfbc_pkg::qstat_type  qstat;
   cfbc_pkg::entry_type  head;
   logic                 pop;

   assign preamble_in = csr_write_enable ? csr_write_data : preamble_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= cfbc_pkg::PREAMBLE_RESET;
      end else begin
         preamble_ff <= preamble_in;
      end
   end

   cfbc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_address        (req_address),
      .req_command_code   (req_command_code),
      .req_command_type   (req_command_type),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .preamble           (preamble_ff),
      .qstat              (qstat),
      .push_out           (push)
   );

   cfbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .qstat   (qstat)
   );

   cfbc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push.push && qstat.full))
      else $error("Entry pushed into a full queue.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("Entry popped from an empty queue.");

   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_byte)
                                    && $stable(rsp_frame_end)))
      else $error("Stalled output transfer changed.");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> (!rsp_valid && qstat.empty))
      else $error("Output or queue not cleared by reset.");

endmodule
